// ===== hw/rtl/psa_pkg.sv =====
// Shared types and constants of the power statistics accumulator.
package psa_pkg;

    // Field widths of the fixed-point formats
    localparam int RES_W        = 16;  // resistance, unsigned Q12.4
    localparam int VOLT_W       = 16;  // voltage, signed Q8.8
    localparam int AMP_W        = 28;  // current, signed Q12.16
    localparam int WATT_W       = 35;  // power, unsigned Q19.16
    localparam int PAIR_COUNT_W = 11;

    // Scaling of the derived quotients
    localparam int CUR_SHIFT = 12;                   // i = v * 4096 / r
    localparam int PWR_SHIFT = 4;                    // p = v * v * 16 / r
    localparam int SQ_W      = 2 * VOLT_W - 1;       // magnitude of v * v
    localparam int CUR_DVD_W = VOLT_W + CUR_SHIFT;   // current dividend
    localparam int PWR_DVD_W = SQ_W + PWR_SHIFT;     // power dividend

    // Saturated quotients for zero resistance
    localparam logic signed [AMP_W-1:0] AMP_POS_SAT = 28'sd134213632;
    localparam logic signed [AMP_W-1:0] AMP_NEG_SAT = 28'h8000000;
    localparam logic [WATT_W-1:0]       WATT_SAT    = 35'h400000000;

    typedef struct packed {
        logic [RES_W-1:0]         resistance;
        logic signed [VOLT_W-1:0] voltage;
        logic                     last_pair;
    } psa_in_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] min_voltage;
        logic signed [VOLT_W-1:0] max_voltage;
        logic signed [VOLT_W-1:0] mean_voltage;
        logic signed [AMP_W-1:0]  low_current;
        logic signed [AMP_W-1:0]  high_current;
        logic signed [AMP_W-1:0]  mean_current;
        logic [WATT_W-1:0]        low_power;
        logic [WATT_W-1:0]        high_power;
        logic [WATT_W-1:0]        mean_power;
        logic [PAIR_COUNT_W-1:0]  pair_count;
        logic                     zero_resistance_seen;
    } psa_out_t;

endpackage

// ===== hw/rtl/psa_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
module psa_div #(
    parameter int DVD_W  = 46,
    parameter int DVS_W  = 16,
    parameter int STEP_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,   // left-aligned: steps bits at the top
    input  logic [DVS_W-1:0]  divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [DVD_W-1:0]  quotient    // quotient in the low steps bits
);

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  q_reg, q_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    // Shift in one dividend bit and try the subtraction
    assign trial = {rem_reg, q_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = !diff[DVS_W];

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            q_next   = dividend;
            dvs_next = divisor;
            cnt_next = steps;
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            q_next    = {q_reg[DVD_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hw/rtl/power_stats_accumulator.sv =====
// Top level: running min, max and mean of voltage, current and power.
//
// Each accepted pair (resistance Q12.4, voltage Q8.8) yields current V/R in Q12.16 and
// power V*V/R in Q19.16, both from one shared bit-serial divider that yields one quotient
// bit per cycle. A pair with nonzero resistance passes the accept, a 28-step current
// division and a 35-step power division, each with its handoff, and the update; a pair
// with zero resistance saturates both quotients and goes from the accept to the update.
// The pair marked last adds three mean divisions of 35 + clog2(MAX_PAIRS+1) steps, each
// with its handoff, then loads the result into the output register once that is free.
// The input is not ready while a pair is being worked on; a finished result waits in
// the output register while the next pairs are taken. After MAX_PAIRS pairs the rest of
// a run is ignored except for its last mark. pair_count is the count taken to 11 bits.
module power_stats_accumulator #(
    parameter int MAX_PAIRS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  psa_pkg::psa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output psa_pkg::psa_out_t m_data
);

    import psa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int VSUM_W = VOLT_W + CNT_W;
    localparam int ASUM_W = AMP_W + CNT_W;
    localparam int WSUM_W = WATT_W + CNT_W;
    localparam int DVD_W  = WSUM_W;
    localparam int DVS_W  = (RES_W > CNT_W) ? RES_W : CNT_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CUR_GO  = 4'd1;
    localparam logic [3:0] ST_CUR_RUN = 4'd2;
    localparam logic [3:0] ST_PWR_GO  = 4'd3;
    localparam logic [3:0] ST_PWR_RUN = 4'd4;
    localparam logic [3:0] ST_UPDATE  = 4'd5;
    localparam logic [3:0] ST_MV_GO   = 4'd6;
    localparam logic [3:0] ST_MV_RUN  = 4'd7;
    localparam logic [3:0] ST_MA_GO   = 4'd8;
    localparam logic [3:0] ST_MA_RUN  = 4'd9;
    localparam logic [3:0] ST_MP_GO   = 4'd10;
    localparam logic [3:0] ST_MP_RUN  = 4'd11;
    localparam logic [3:0] ST_EMIT    = 4'd12;

    logic [3:0] state_reg, state_next;

    // Current pair
    logic [RES_W-1:0]         r_reg, r_next;
    logic signed [VOLT_W-1:0] v_reg, v_next;
    logic                     last_reg, last_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic signed [AMP_W-1:0]  cur_reg, cur_next;
    logic [WATT_W-1:0]        pwr_reg, pwr_next;

    // Run statistics
    logic signed [VOLT_W-1:0] vmin_reg, vmin_next, vmax_reg, vmax_next;
    logic signed [AMP_W-1:0]  amin_reg, amin_next, amax_reg, amax_next;
    logic [WATT_W-1:0]        wmin_reg, wmin_next, wmax_reg, wmax_next;
    logic signed [VSUM_W-1:0] vsum_reg, vsum_next;
    logic signed [ASUM_W-1:0] asum_reg, asum_next;
    logic [WSUM_W-1:0]        wsum_reg, wsum_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     open_reg, open_next;
    logic                     zflag_reg, zflag_next;

    // Means
    logic signed [VOLT_W-1:0] vmean_reg, vmean_next;
    logic signed [AMP_W-1:0]  amean_reg, amean_next;
    logic [WATT_W-1:0]        wmean_reg, wmean_next;

    // Output register
    psa_out_t out_reg, out_next;
    logic     mvalid_reg, mvalid_next;

    // Divider hookup
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [STEP_W-1:0] div_steps;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;

    logic signed [2*VOLT_W-1:0] sq_full;
    logic [VOLT_W-1:0]          vmag;
    logic [VSUM_W-1:0]          vsum_mag;
    logic [ASUM_W-1:0]          asum_mag;
    logic                       counting;
    logic                       s_fire;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign counting = (cnt_reg < CNT_W'(MAX_PAIRS));
    assign sq_full  = s_data.voltage * s_data.voltage;
    assign vmag     = v_reg[VOLT_W-1] ? VOLT_W'(-v_reg) : VOLT_W'(v_reg);
    assign vsum_mag = vsum_reg[VSUM_W-1] ? VSUM_W'(-vsum_reg) : VSUM_W'(vsum_reg);
    assign asum_mag = asum_reg[ASUM_W-1] ? ASUM_W'(-asum_reg) : ASUM_W'(asum_reg);

    // Feed the divider by sequencer step
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = DVS_W'(cnt_reg);
        div_steps = STEP_W'(DVD_W);
        unique case (state_reg)
            ST_CUR_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({vmag, {CUR_SHIFT{1'b0}}}) << (DVD_W - CUR_DVD_W);
                div_dvs   = DVS_W'(r_reg);
                div_steps = STEP_W'(CUR_DVD_W);
            end
            ST_PWR_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({sq_reg, {PWR_SHIFT{1'b0}}}) << (DVD_W - PWR_DVD_W);
                div_dvs   = DVS_W'(r_reg);
                div_steps = STEP_W'(PWR_DVD_W);
            end
            ST_MV_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(vsum_mag);
            end
            ST_MA_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(asum_mag);
            end
            ST_MP_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(wsum_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    psa_div #(
        .DVD_W  (DVD_W),
        .DVS_W  (DVS_W),
        .STEP_W (STEP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequence one transaction through the shared divider
    always_comb begin
        state_next  = state_reg;
        r_next      = r_reg;
        v_next      = v_reg;
        last_next   = last_reg;
        sq_next     = sq_reg;
        cur_next    = cur_reg;
        pwr_next    = pwr_reg;
        vmin_next   = vmin_reg;
        vmax_next   = vmax_reg;
        amin_next   = amin_reg;
        amax_next   = amax_reg;
        wmin_next   = wmin_reg;
        wmax_next   = wmax_reg;
        vsum_next   = vsum_reg;
        asum_next   = asum_reg;
        wsum_next   = wsum_reg;
        cnt_next    = cnt_reg;
        open_next   = open_reg;
        zflag_next  = zflag_reg;
        vmean_next  = vmean_reg;
        amean_next  = amean_reg;
        wmean_next  = wmean_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    r_next    = s_data.resistance;
                    v_next    = s_data.voltage;
                    last_next = s_data.last_pair;
                    sq_next   = sq_full[SQ_W-1:0];
                    if (counting) begin
                        if (s_data.resistance == '0) begin
                            // Saturate both quotients on zero resistance
                            zflag_next = 1'b1;
                            if (s_data.voltage > 0) begin
                                cur_next = AMP_POS_SAT;
                            end else if (s_data.voltage < 0) begin
                                cur_next = AMP_NEG_SAT;
                            end else begin
                                cur_next = '0;
                            end
                            pwr_next   = (s_data.voltage != 0) ? WATT_SAT : '0;
                            state_next = ST_UPDATE;
                        end else begin
                            state_next = ST_CUR_GO;
                        end
                    end else if (s_data.last_pair) begin
                        state_next = ST_MV_GO;
                    end
                end
            end
            ST_CUR_GO: begin
                state_next = ST_CUR_RUN;
            end
            ST_CUR_RUN: begin
                if (div_done) begin
                    cur_next   = v_reg[VOLT_W-1] ? AMP_W'(-div_q[AMP_W-1:0])
                                                 : div_q[AMP_W-1:0];
                    state_next = ST_PWR_GO;
                end
            end
            ST_PWR_GO: begin
                state_next = ST_PWR_RUN;
            end
            ST_PWR_RUN: begin
                if (div_done) begin
                    pwr_next   = div_q[WATT_W-1:0];
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // Seed or widen the extremes, then accumulate
                if (!open_reg) begin
                    vmin_next = v_reg;
                    vmax_next = v_reg;
                    amin_next = cur_reg;
                    amax_next = cur_reg;
                    wmin_next = pwr_reg;
                    wmax_next = pwr_reg;
                    open_next = 1'b1;
                end else begin
                    if (v_reg < vmin_reg)     vmin_next = v_reg;
                    if (v_reg > vmax_reg)     vmax_next = v_reg;
                    if (cur_reg < amin_reg)   amin_next = cur_reg;
                    if (cur_reg > amax_reg)   amax_next = cur_reg;
                    if (pwr_reg < wmin_reg)   wmin_next = pwr_reg;
                    if (pwr_reg > wmax_reg)   wmax_next = pwr_reg;
                end
                vsum_next  = vsum_reg + VSUM_W'(v_reg);
                asum_next  = asum_reg + ASUM_W'(cur_reg);
                wsum_next  = wsum_reg + WSUM_W'(pwr_reg);
                cnt_next   = cnt_reg + 1'b1;
                state_next = last_reg ? ST_MV_GO : ST_IDLE;
            end
            ST_MV_GO: begin
                state_next = ST_MV_RUN;
            end
            ST_MV_RUN: begin
                if (div_done) begin
                    vmean_next = vsum_reg[VSUM_W-1] ? VOLT_W'(-div_q[VOLT_W-1:0])
                                                    : div_q[VOLT_W-1:0];
                    state_next = ST_MA_GO;
                end
            end
            ST_MA_GO: begin
                state_next = ST_MA_RUN;
            end
            ST_MA_RUN: begin
                if (div_done) begin
                    amean_next = asum_reg[ASUM_W-1] ? AMP_W'(-div_q[AMP_W-1:0])
                                                    : div_q[AMP_W-1:0];
                    state_next = ST_MP_GO;
                end
            end
            ST_MP_GO: begin
                state_next = ST_MP_RUN;
            end
            ST_MP_RUN: begin
                if (div_done) begin
                    wmean_next = div_q[WATT_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free, then load and close the run
                if (!mvalid_reg || m_ready) begin
                    out_next.min_voltage          = vmin_reg;
                    out_next.max_voltage          = vmax_reg;
                    out_next.mean_voltage         = vmean_reg;
                    out_next.low_current          = amin_reg;
                    out_next.high_current         = amax_reg;
                    out_next.mean_current         = amean_reg;
                    out_next.low_power            = wmin_reg;
                    out_next.high_power           = wmax_reg;
                    out_next.mean_power           = wmean_reg;
                    out_next.pair_count           = PAIR_COUNT_W'(cnt_reg);
                    out_next.zero_resistance_seen = zflag_reg;
                    mvalid_next = 1'b1;
                    vmin_next   = '0;
                    vmax_next   = '0;
                    amin_next   = '0;
                    amax_next   = '0;
                    wmin_next   = '0;
                    wmax_next   = '0;
                    vsum_next   = '0;
                    asum_next   = '0;
                    wsum_next   = '0;
                    cnt_next    = '0;
                    open_next   = 1'b0;
                    zflag_next  = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        r_reg     <= r_next;
        v_reg     <= v_next;
        last_reg  <= last_next;
        sq_reg    <= sq_next;
        cur_reg   <= cur_next;
        pwr_reg   <= pwr_next;
        vmin_reg  <= vmin_next;
        vmax_reg  <= vmax_next;
        amin_reg  <= amin_next;
        amax_reg  <= amax_next;
        wmin_reg  <= wmin_next;
        wmax_reg  <= wmax_next;
        vmean_reg <= vmean_next;
        amean_reg <= amean_next;
        wmean_reg <= wmean_next;
        out_reg   <= out_next;
    end

    // Control and accumulator registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            vsum_reg   <= '0;
            asum_reg   <= '0;
            wsum_reg   <= '0;
            cnt_reg    <= '0;
            open_reg   <= 1'b0;
            zflag_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            vsum_reg   <= vsum_next;
            asum_reg   <= asum_next;
            wsum_reg   <= wsum_next;
            cnt_reg    <= cnt_next;
            open_reg   <= open_next;
            zflag_reg  <= zflag_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

endmodule

// ===== verif/power_stats_accumulator_tb.sv =====
// Self-checking testbench for the power statistics accumulator.
module power_stats_accumulator_tb;
    import psa_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_PAIRS    = 1024;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 3000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_PAIRS = 60;

    // Running statistics of the open run, as the block should hold them
    typedef struct {
        longint v_lo, v_hi, v_sum;
        longint i_lo, i_hi, i_sum;
        longint p_lo, p_hi, p_sum;
        int     pairs;
        bit     seeded;
        bit     zero_ohm;
    } run_stats_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    psa_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    psa_out_t m_data;

    run_stats_t run_acc = '{default: 0};
    psa_out_t   pending_stats[$];
    int         failures      = 0;
    bit         fast_mode     = 1'b0;
    int         holds_asked   = 0;
    int         holds_granted = 0;
    int         hold_left     = 0;

    power_stats_accumulator #(
        .MAX_PAIRS(MAX_PAIRS)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // Fold one accepted pair into the run; return 1 with the statistics when the run closes
    function automatic bit fold_pair(input psa_in_t item, output psa_out_t stats);
        longint volts, ohms, amps, watts;
        volts = longint'(item.voltage);
        ohms  = longint'(item.resistance);
        stats = '0;
        if (run_acc.pairs < MAX_PAIRS) begin
            if (ohms == 0) begin
                amps  = (volts > 0) ? longint'(AMP_POS_SAT)
                      : ((volts < 0) ? longint'(AMP_NEG_SAT) : longint'(0));
                watts = (volts != 0) ? longint'(WATT_SAT) : longint'(0);
                run_acc.zero_ohm = 1'b1;
            end else begin
                amps  = (volts * 4096) / ohms;
                watts = (volts * volts * 16) / ohms;
            end
            if (!run_acc.seeded) begin
                run_acc.v_lo   = volts;
                run_acc.v_hi   = volts;
                run_acc.i_lo   = amps;
                run_acc.i_hi   = amps;
                run_acc.p_lo   = watts;
                run_acc.p_hi   = watts;
                run_acc.seeded = 1'b1;
            end else begin
                if (volts < run_acc.v_lo) run_acc.v_lo = volts;
                if (volts > run_acc.v_hi) run_acc.v_hi = volts;
                if (amps < run_acc.i_lo) run_acc.i_lo = amps;
                if (amps > run_acc.i_hi) run_acc.i_hi = amps;
                if (watts < run_acc.p_lo) run_acc.p_lo = watts;
                if (watts > run_acc.p_hi) run_acc.p_hi = watts;
            end
            run_acc.v_sum += volts;
            run_acc.i_sum += amps;
            run_acc.p_sum += watts;
            run_acc.pairs++;
        end
        if (!item.last_pair) return 1'b0;
        stats.min_voltage          = VOLT_W'(run_acc.v_lo);
        stats.max_voltage          = VOLT_W'(run_acc.v_hi);
        stats.mean_voltage         = VOLT_W'(run_acc.v_sum / run_acc.pairs);
        stats.low_current          = AMP_W'(run_acc.i_lo);
        stats.high_current         = AMP_W'(run_acc.i_hi);
        stats.mean_current         = AMP_W'(run_acc.i_sum / run_acc.pairs);
        stats.low_power            = WATT_W'(run_acc.p_lo);
        stats.high_power           = WATT_W'(run_acc.p_hi);
        stats.mean_power           = WATT_W'(run_acc.p_sum / run_acc.pairs);
        stats.pair_count           = PAIR_COUNT_W'(run_acc.pairs);
        stats.zero_resistance_seen = run_acc.zero_ohm;
        run_acc = '{default: 0};
        return 1'b1;
    endfunction

    function automatic logic signed [VOLT_W-1:0] rand_voltage();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            1:       return VOLT_W'($urandom_range(0, 8) - 4);
            default: return VOLT_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic logic [RES_W-1:0] rand_resistance();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return RES_W'($urandom_range(1, 15));
            2:       return 16'hffff;
            default: return RES_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // Offer one pair after a random gap, or none in fast mode, and hold it until accepted
    task automatic send_pair(input logic [RES_W-1:0] ohms,
                             input logic signed [VOLT_W-1:0] volts, input logic last);
        int       gap;
        psa_out_t stats;
        gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{resistance: ohms, voltage: volts, last_pair: last};
        do @(posedge aclk); while (!s_ready);
        if (fold_pair('{resistance: ohms, voltage: volts, last_pair: last}, stats))
            pending_stats.push_back(stats);
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
        end
    endtask

    task automatic check_stats(input psa_out_t seen);
        psa_out_t want;
        if (pending_stats.size() == 0) begin
            $error("statistics transaction with none pending");
            failures++;
            return;
        end
        want = pending_stats.pop_front();
        compare_field("min_voltage", 64'(want.min_voltage), 64'(seen.min_voltage));
        compare_field("max_voltage", 64'(want.max_voltage), 64'(seen.max_voltage));
        compare_field("mean_voltage", 64'(want.mean_voltage), 64'(seen.mean_voltage));
        compare_field("low_current", 64'(want.low_current), 64'(seen.low_current));
        compare_field("high_current", 64'(want.high_current), 64'(seen.high_current));
        compare_field("mean_current", 64'(want.mean_current), 64'(seen.mean_current));
        compare_field("low_power", 64'(want.low_power), 64'(seen.low_power));
        compare_field("high_power", 64'(want.high_power), 64'(seen.high_power));
        compare_field("mean_power", 64'(want.mean_power), 64'(seen.mean_power));
        compare_field("pair_count", 64'(want.pair_count), 64'(seen.pair_count));
        compare_field("zero_resistance_seen", 64'(want.zero_resistance_seen),
                      64'(seen.zero_resistance_seen));
    endtask

    // Check each result, then stall the result channel for a random or requested stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) check_stats(m_data);
            if (holds_granted != holds_asked) begin
                holds_granted++;
                hold_left = LONG_HOLD;
            end else if (m_valid && m_ready) begin
                hold_left = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_ready <= (hold_left == 0);
        end
    end

    // Corner voltages and resistances, saturation, single-pair runs and short runs
    task automatic test_extreme_values();
        send_pair(16'd1, 16'sh7fff, 1'b1);
        send_pair(16'd1, 16'sh8000, 1'b1);
        send_pair(16'hffff, 16'sh7fff, 1'b1);
        send_pair(16'hffff, -16'sd1, 1'b1);
        send_pair(16'd0, 16'sd0, 1'b1);
        send_pair(16'd0, 16'sd300, 1'b0);
        send_pair(16'd0, -16'sd300, 1'b0);
        send_pair(16'd0, 16'sd0, 1'b0);
        send_pair(16'd16, 16'sd256, 1'b1);
        send_pair(16'h5555, 16'sh5555, 1'b0);
        send_pair(16'haaaa, 16'shaaaa, 1'b0);
        send_pair(16'h8000, 16'sd1, 1'b0);
        send_pair(16'd1, -16'sd1, 1'b0);
        send_pair(16'd7, 16'sh7fff, 1'b0);
        send_pair(16'd3, 16'sh8000, 1'b1);
        send_pair(16'd1, 16'sd0, 1'b1);
    endtask

    // Run longer than MAX_PAIRS: extra pairs, all with zero resistance, are dropped
    task automatic test_run_overflow();
        logic [RES_W-1:0] ohms;
        for (int k = 0; k < MAX_PAIRS + 6; k++) begin
            ohms = rand_resistance();
            if (k >= MAX_PAIRS) ohms = '0;
            else if (ohms == 0) ohms = 16'd1;
            send_pair(ohms, rand_voltage(), k == MAX_PAIRS + 5);
        end
        send_pair(rand_resistance(), rand_voltage(), 1'b1);
    endtask

    // Hold the result channel off while short runs keep coming, so the input stalls
    task automatic test_result_backpressure();
        holds_asked++;
        for (int k = 0; k < 8; k++) begin
            send_pair(rand_resistance(), rand_voltage(), 1'b0);
            send_pair(rand_resistance(), rand_voltage(), 1'b1);
        end
    endtask

    // Runs of random length and content, some stretches without idling
    task automatic test_random_runs();
        int sent;
        int run_len;
        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            case ($urandom_range(0, 9))
                0:       run_len = 1;
                1, 2:    run_len = $urandom_range(13, 40);
                default: run_len = $urandom_range(2, 12);
            endcase
            fast_mode = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < run_len; k++)
                send_pair(rand_resistance(), rand_voltage(), k == run_len - 1);
            sent += run_len;
        end
        fast_mode = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_values();
        test_run_overflow();
        test_result_backpressure();
        test_random_runs();
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(CLK_PERIOD * 2_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
